// ===== rtl/ror_pkg.sv =====
// Shared types and constants for the ring of records with offset lookup.
`default_nettype none

package ror_pkg;

  localparam int HANDLE_W  = 32;
  localparam int ENTRY_W   = 16;
  localparam int OFFSET_W  = 20;
  localparam int WITHIN_W  = 16;
  localparam int SLOT_W    = 4;

  localparam logic ACTION_ADD  = 1'b0;
  localparam logic ACTION_FIND = 1'b1;

  typedef struct packed {
    logic add;
    logic load;
    logic step;
    logic done_hit;
    logic done_miss;
  } ror_cmd_t;

  typedef struct packed {
    logic empty;
    logic match;
    logic last;
  } ror_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ror_ctrl.sv =====
// Controller state machine that sequences adds and record walks.
`default_nettype none

module ror_ctrl
  import ror_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      action,
  input  wire ror_stat_t stat,
  output ror_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic {IDLE, WALK} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) begin
          if (action == ACTION_ADD) begin
            cmd.add = 1'b1;
          end else if (stat.empty) begin
            cmd.done_miss = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = WALK;
          end
        end
      end
      WALK: begin
        if (stat.match) begin
          cmd.done_hit = 1'b1;
          state_next   = IDLE;
        end else if (stat.last) begin
          cmd.done_miss = 1'b1;
          state_next    = IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == WALK);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ror_dp.sv =====
// Datapath with the record memories, ring pointers, walk registers and result registers.
`default_nettype none

module ror_dp
  import ror_pkg::*;
#(
  parameter int RING_DEPTH  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ror_cmd_t            cmd,
  input  wire logic [HANDLE_W-1:0] entry_handle,
  input  wire logic [ENTRY_W-1:0]  entry_length,
  input  wire logic [OFFSET_W-1:0] find_offset,
  output ror_stat_t                stat,
  output logic                     done,
  output logic                     hit,
  output logic [HANDLE_W-1:0]      found_handle,
  output logic [WITHIN_W-1:0]      byte_within,
  output logic [SLOT_W-1:0]        found_slot,
  output logic                     ring_full
);

  localparam int SW  = $clog2(RING_DEPTH);
  localparam int CNW = SW + 1;
  localparam int LW  = LENGTH_BITS;
  localparam int CW  = ((LW + SW > OFFSET_W) ? LW + SW : OFFSET_W) + 1;
  localparam int EXW = (LW > ENTRY_W) ? LW : ENTRY_W;
  localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;

  logic [HANDLE_W-1:0] hmem [RING_DEPTH];
  logic [LW-1:0]       lmem [RING_DEPTH];

  logic [SW-1:0]       wr_slot;
  logic [SW-1:0]       rd_slot;
  logic                full;
  logic [SW-1:0]       idx;
  logic [CNW-1:0]      remaining;
  logic [CW-1:0]       sum;
  logic [OFFSET_W-1:0] offset;
  logic [HANDLE_W-1:0] rd_handle;
  logic [LW-1:0]       rd_len;

  logic [SW-1:0]       wr_inc;
  logic [SW-1:0]       rd_inc;
  logic [SW-1:0]       idx_inc;
  logic [SW-1:0]       rd_addr;
  logic [CNW-1:0]      count;
  logic [CW-1:0]       sum_next;
  logic [CW-1:0]       diff;
  logic [EXW-1:0]      len_x;
  logic [SXW-1:0]      idx_x;

  assign wr_inc  = (wr_slot == SW'(RING_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
  assign rd_inc  = (rd_slot == SW'(RING_DEPTH - 1)) ? '0 : rd_slot + 1'b1;
  assign idx_inc = (idx == SW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  assign rd_addr = cmd.step ? idx_inc : rd_slot;

  always_comb begin
    if (full) begin
      count = CNW'(RING_DEPTH);
    end else if (wr_slot >= rd_slot) begin
      count = CNW'(wr_slot) - CNW'(rd_slot);
    end else begin
      count = CNW'(wr_slot) + CNW'(RING_DEPTH) - CNW'(rd_slot);
    end
  end

  assign sum_next   = sum + CW'(rd_len);
  assign diff       = CW'(offset) - sum;
  assign len_x      = EXW'(entry_length);
  assign idx_x      = SXW'(idx);
  assign stat.empty = (count == '0);
  assign stat.match = (CW'(offset) < sum_next);
  assign stat.last  = (remaining == CNW'(1));

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      hmem[wr_slot] <= entry_handle;
      lmem[wr_slot] <= len_x[LW-1:0];
    end
    rd_handle <= hmem[rd_addr];
    rd_len    <= lmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= '0;
      rd_slot <= '0;
      full    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= cmd.add | cmd.done_hit | cmd.done_miss;
      if (cmd.add) begin
        wr_slot <= wr_inc;
        if (full) begin
          rd_slot <= rd_inc;
        end
        full <= (wr_inc == (full ? rd_inc : rd_slot));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx       <= rd_slot;
      remaining <= count;
      sum       <= '0;
      offset    <= find_offset;
    end else if (cmd.step) begin
      idx       <= idx_inc;
      remaining <= remaining - 1'b1;
      sum       <= sum_next;
    end
    if (cmd.done_hit) begin
      hit          <= 1'b1;
      found_handle <= rd_handle;
      byte_within  <= diff[WITHIN_W-1:0];
      found_slot   <= idx_x[SLOT_W-1:0];
      ring_full    <= full;
    end else if (cmd.done_miss) begin
      hit          <= 1'b0;
      found_handle <= '0;
      byte_within  <= '0;
      found_slot   <= '0;
      ring_full    <= full;
    end else if (cmd.add) begin
      hit          <= 1'b0;
      found_handle <= '0;
      byte_within  <= '0;
      found_slot   <= '0;
      ring_full    <= (wr_inc == (full ? rd_inc : rd_slot));
    end
  end

  // A full ring always has its write and read slots together.
  a_full_slots: assert property (@(posedge clk) disable iff (rst)
    full |-> (wr_slot == rd_slot))
    else $error("full flag set with write and read slots apart");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_step_left: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (remaining > CNW'(1)))
    else $error("walk stepped past the stored records");

  // A find never moves the ring pointers.
  a_walk_stable: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.load) |=> ($stable(wr_slot) && $stable(rd_slot) && $stable(full)))
    else $error("ring pointers changed during a find");

endmodule

`default_nettype wire

// ===== rtl/ring_of_records_with_offset_lookup.sv =====
// Top level of the ring of records with offset lookup.
//
//   Channel   Handshake            Ports
//   request   start & !busy        action, entry_handle, entry_length, find_offset
//   result    done, one cycle      hit, found_handle, byte_within, found_slot, ring_full
//
// An add's result strobes in the cycle after acceptance.
// A find walks the stored records, up to count of them (at most RING_DEPTH);
// the walk reads one record a cycle from the record memory.
// A find on an empty ring answers as a miss in the cycle after acceptance.
// Reset is synchronous and empties the ring; memory contents are not cleared.
// busy is high while a walk runs; the result strobe cannot be held off.
`default_nettype none

module ring_of_records_with_offset_lookup
  import ror_pkg::*;
#(
  parameter int RING_DEPTH  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                action,
  input  wire logic [HANDLE_W-1:0] entry_handle,
  input  wire logic [ENTRY_W-1:0]  entry_length,
  input  wire logic [OFFSET_W-1:0] find_offset,
  output logic                     done,
  output logic                     hit,
  output logic [HANDLE_W-1:0]      found_handle,
  output logic [WITHIN_W-1:0]      byte_within,
  output logic [SLOT_W-1:0]        found_slot,
  output logic                     ring_full
);

  ror_cmd_t  cmd;
  ror_stat_t stat;

  ror_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  ror_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .entry_handle (entry_handle),
    .entry_length (entry_length),
    .find_offset  (find_offset),
    .stat         (stat),
    .done         (done),
    .hit          (hit),
    .found_handle (found_handle),
    .byte_within  (byte_within),
    .found_slot   (found_slot),
    .ring_full    (ring_full)
  );

endmodule

`default_nettype wire
